// File: rtl/nspt_pkg.sv
// shared types and constants of the nearest steep point tracker
package nspt_pkg;

  typedef struct packed {
    logic        mirror_xy;
    logic [9:0]  x_offset_mm;
    logic [10:0] pair_gap_mm;
    logic [15:0] slope_ratio_q8;
    logic [29:0] near_reject_sq;
    logic [29:0] min_publish_sq;
    logic [8:0]  smoothing_q8;
  } nspt_cfg_t;

  typedef enum logic [2:0] {
    REG_MIRROR_XY   = 3'd0,
    REG_X_OFFSET    = 3'd1,
    REG_PAIR_GAP    = 3'd2,
    REG_SLOPE_RATIO = 3'd3,
    REG_NEAR_REJECT = 3'd4,
    REG_MIN_PUBLISH = 3'd5,
    REG_SMOOTHING   = 3'd6
  } nspt_reg_e;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [63:0] NearKey      = 64'd10_000_000_000;
  localparam logic [63:0] BestKeyReset = 64'd1_000_000_000_000;
  localparam logic [8:0]  AlphaOne     = 9'd256;
  localparam int unsigned AlphaShift   = 8;

  localparam nspt_cfg_t CfgReset = '{
    mirror_xy:      1'b1,
    x_offset_mm:    10'd200,
    pair_gap_mm:    11'd200,
    slope_ratio_q8: 16'd955,
    near_reject_sq: 30'd300000,
    min_publish_sq: 30'd90000,
    smoothing_q8:   9'd77
  };

endpackage

// File: rtl/nspt_front.sv
// front end: accepts points, flags skipped ones and applies the x offset
module nspt_front import nspt_pkg::*; #(
  parameter int unsigned COORD_BITS = 18,
  parameter int unsigned ITEM_BITS  = 3 * COORD_BITS + 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] x_mm_i,
  input  logic signed [COORD_BITS-1:0] y_mm_i,
  input  logic signed [COORD_BITS-1:0] z_mm_i,
  input  logic                         last_in_scan_i,
  input  nspt_cfg_t                    cfg_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output logic [ITEM_BITS-1:0]         q_item_o
);

  logic signed [COORD_BITS:0] x_ext;
  logic signed [COORD_BITS:0] off_ext;
  logic signed [COORD_BITS:0] px;
  logic                       pt_ok;
  logic                       seen_q;

  assign x_ext   = (COORD_BITS+1)'(x_mm_i);
  assign off_ext = $signed((COORD_BITS+1)'(cfg_i.x_offset_mm));
  assign px      = cfg_i.mirror_xy ? x_ext + off_ext : x_ext - off_ext;
  assign pt_ok   = (x_mm_i != '0) && (y_mm_i != '0) && (z_mm_i != '0);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_item_o   = {pt_ok, last_in_scan_i, px, y_mm_i, z_mm_i};

  // tracks whether the current scan has delivered any word yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (q_push_o) begin
      seen_q <= !last_in_scan_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full_i |-> !q_push_o) else $error("push into full queue");
  a_seen_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && last_in_scan_i) |=> !seen_q) else $error("scan flag not cleared");
  a_skip_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && x_mm_i == '0) |-> !q_item_o[ITEM_BITS-1]) else $error("zero point kept");
`endif

endmodule

// File: rtl/nspt_fifo.sv
// short word queue between front end and back end
module nspt_fifo #(
  parameter int unsigned WIDTH = 57,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

`ifndef SYNTHESIS
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif

endmodule

// File: rtl/nspt_back.sv
// back end: range, root, steepness test, best point and scan end filter
module nspt_back import nspt_pkg::*; #(
  parameter int unsigned COORD_BITS = 18,
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned ITEM_BITS  = 3 * COORD_BITS + 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nspt_cfg_t                    cfg_i,
  input  logic                         q_valid_i,
  input  logic [ITEM_BITS-1:0]         q_item_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] smooth_x_o,
  output logic signed [COORD_BITS-1:0] smooth_y_o,
  output logic signed [COORD_BITS-1:0] smooth_z_o,
  output logic                         updated_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned RB    = C + 1;
  localparam int unsigned HB    = 2 * RB;
  localparam int unsigned KW    = (2 * C + 3 > 40) ? 2 * C + 3 : 40;
  localparam int unsigned PW    = (HB > 30) ? HB : 30;
  localparam int unsigned FW    = C + FRAC_BITS;
  localparam int unsigned AW    = FW + 10;
  localparam int unsigned MW    = C + FRAC_BITS + 1;
  localparam int unsigned CNTW  = $clog2(RB);
  localparam int unsigned SPW   = 16 + RB;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQZ, S_ROOT, S_SLOPE, S_TEST,
    S_B0, S_B1, S_B2, S_PUB, S_FM1, S_FM2, S_FRND, S_LOAD
  } state_e;

  state_e state_q;

  logic                   last_q;
  logic signed [C:0]      px_q;
  logic signed [C-1:0]    py_q, pz_q;
  logic [C:0]             ax_q;
  logic [C-1:0]           ay_q, az_q;
  logic [HB-1:0]          hsq_q, sh_q;
  logic [KW-1:0]          key_q, best_key_q;
  logic [RB-1:0]          root_q;
  logic [RB+1:0]          rem_q;
  logic [CNTW-1:0]        cnt_q;
  logic [SPW-1:0]         sprod_q;
  logic                   have_prev_q;
  logic signed [C:0]      prev_x_q;
  logic signed [C-1:0]    prev_y_q, prev_z_q;
  logic [RB-1:0]          prev_rad_q;
  logic signed [C:0]      best_pt_q [3];
  logic [PW-1:0]          bsum_q;
  logic                   upd_q;
  logic [1:0]             k_q;
  logic signed [AW-1:0]   acc_q;
  logic signed [FW-1:0]   filt_q [3];
  logic                   out_valid_q;
  logic signed [C-1:0]    out_q [3];
  logic                   out_upd_q;

  // item fields
  logic                   it_ok, it_last;
  logic signed [C:0]      it_px;
  logic signed [C-1:0]    it_py, it_pz;

  assign {it_ok, it_last, it_px, it_py, it_pz} = q_item_i;

  // shared multiplier
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] prod;

  // filter operands
  logic [8:0]             alpha;
  logic signed [C:0]      bp_k;
  logic signed [C+1:0]    tgt_w;
  logic signed [C-1:0]    tgt;
  logic [C:0]             bmag;

  assign alpha = (cfg_i.smoothing_q8 > AlphaOne) ? AlphaOne : cfg_i.smoothing_q8;
  assign bp_k  = best_pt_q[k_q];
  assign bmag  = bp_k[C] ? (C+1)'(-bp_k) : (C+1)'(bp_k);
  assign tgt_w = (cfg_i.mirror_xy && k_q != 2'd2) ? -(C+2)'(bp_k) : (C+2)'(bp_k);
  always_comb begin
    if (tgt_w > (C+2)'(2**(C-1) - 1)) begin
      tgt = {1'b0, {(C-1){1'b1}}};
    end else if (tgt_w < -(C+2)'(2**(C-1))) begin
      tgt = {1'b1, {(C-1){1'b0}}};
    end else begin
      tgt = C'(tgt_w);
    end
  end

  logic [RB-1:0] dr;
  assign dr = (root_q > prev_rad_q) ? root_q - prev_rad_q : prev_rad_q - root_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQX:   begin mul_a = MW'(ax_q); mul_b = MW'(ax_q); end
      S_SQY:   begin mul_a = MW'(ay_q); mul_b = MW'(ay_q); end
      S_SQZ:   begin mul_a = MW'(az_q); mul_b = MW'(az_q); end
      S_SLOPE: begin mul_a = MW'(cfg_i.slope_ratio_q8); mul_b = MW'(dr); end
      S_B0, S_B1, S_B2: begin mul_a = MW'(bmag); mul_b = MW'(bmag); end
      S_FM1:   begin mul_a = MW'(filt_q[k_q]); mul_b = MW'(AlphaOne - alpha); end
      S_FM2:   begin mul_a = MW'(tgt); mul_b = MW'(alpha); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;

  // root step
  logic [RB+1:0] rem_sh, trial;
  logic          root_ge;
  assign rem_sh  = {rem_q[RB-1:0], sh_q[HB-1:HB-2]};
  assign trial   = {root_q, 2'b01};
  assign root_ge = (rem_sh >= trial);

  // pair test
  logic signed [C+1:0] dx;
  logic signed [C:0]   dy, dz;
  logic [C+1:0]        adx;
  logic [C:0]          ady, adz;
  logic                steep, paired;
  logic [KW-1:0]       key_sel;

  assign dx     = (C+2)'(px_q) - (C+2)'(prev_x_q);
  assign dy     = (C+1)'(py_q) - (C+1)'(prev_y_q);
  assign dz     = (C+1)'(pz_q) - (C+1)'(prev_z_q);
  assign adx    = dx[C+1] ? (C+2)'(-dx) : (C+2)'(dx);
  assign ady    = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
  assign adz    = dz[C] ? (C+1)'(-dz) : (C+1)'(dz);
  // a flat pair never passes since zero is never above the product
  assign steep  = (SPW'({adz, 8'd0}) > sprod_q);
  assign paired = have_prev_q && (adx < (C+2)'(cfg_i.pair_gap_mm))
                  && (ady < (C+1)'(cfg_i.pair_gap_mm));
  assign key_sel = (key_q < KW'(cfg_i.near_reject_sq)) ? KW'(NearKey) : key_q;

  // filter rounding
  logic signed [AW-1:0] fr;
  logic signed [FW-1:0] fnew;
  assign fr = (acc_q + AW'(2**(AlphaShift-1))) >>> AlphaShift;
  always_comb begin
    if (fr > AW'(2**(FW-1) - 1)) begin
      fnew = {1'b0, {(FW-1){1'b1}}};
    end else if (fr < -AW'(2**(FW-1))) begin
      fnew = {1'b1, {(FW-1){1'b0}}};
    end else begin
      fnew = FW'(fr);
    end
  end

  // output rounding
  logic signed [FW:0]   orw [3];
  logic signed [C-1:0]  ov [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      orw[i] = ((FW+1)'(filt_q[i]) + (FW+1)'(2**(FRAC_BITS-1))) >>> FRAC_BITS;
      if (orw[i] > (FW+1)'(2**(C-1) - 1)) begin
        ov[i] = {1'b0, {(C-1){1'b1}}};
      end else begin
        ov[i] = C'(orw[i]);
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_prev_q <= 1'b0;
      best_key_q  <= KW'(BestKeyReset);
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      k_q         <= '0;
      upd_q       <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
      prev_rad_q  <= '0;
      last_q      <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      az_q        <= '0;
      hsq_q       <= '0;
      sh_q        <= '0;
      key_q       <= '0;
      root_q      <= '0;
      rem_q       <= '0;
      sprod_q     <= '0;
      bsum_q      <= '0;
      acc_q       <= '0;
      out_upd_q   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        best_pt_q[i] <= '0;
        filt_q[i]    <= '0;
        out_q[i]     <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_LOAD) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            last_q  <= it_last;
            px_q    <= it_px;
            py_q    <= it_py;
            pz_q    <= it_pz;
            ax_q    <= it_px[C] ? (C+1)'(-it_px) : (C+1)'(it_px);
            ay_q    <= it_py[C-1] ? C'(-it_py) : C'(it_py);
            az_q    <= it_pz[C-1] ? C'(-it_pz) : C'(it_pz);
            if (it_ok) begin
              state_q <= S_SQX;
            end else if (it_last) begin
              state_q <= S_B0;
            end
          end
        end
        S_SQX: begin
          hsq_q   <= HB'(prod);
          state_q <= S_SQY;
        end
        S_SQY: begin
          hsq_q   <= hsq_q + HB'(prod);
          state_q <= S_SQZ;
        end
        S_SQZ: begin
          key_q   <= KW'(hsq_q) + KW'(prod);
          sh_q    <= hsq_q;
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= '0;
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          sh_q   <= {sh_q[HB-3:0], 2'b00};
          rem_q  <= root_ge ? rem_sh - trial : rem_sh;
          root_q <= {root_q[RB-2:0], root_ge};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(RB - 1)) begin
            state_q <= S_SLOPE;
          end
        end
        S_SLOPE: begin
          sprod_q <= SPW'(prod);
          state_q <= S_TEST;
        end
        S_TEST: begin
          if (paired && steep && key_sel < best_key_q) begin
            best_key_q   <= key_sel;
            best_pt_q[0] <= px_q;
            best_pt_q[1] <= (C+1)'(py_q);
            best_pt_q[2] <= (C+1)'(pz_q);
          end
          have_prev_q <= 1'b1;
          prev_x_q    <= px_q;
          prev_y_q    <= py_q;
          prev_z_q    <= pz_q;
          prev_rad_q  <= root_q;
          k_q         <= '0;
          state_q     <= last_q ? S_B0 : S_IDLE;
        end
        S_B0: begin
          bsum_q  <= PW'(prod);
          k_q     <= 2'd1;
          state_q <= S_B1;
        end
        S_B1: begin
          bsum_q  <= bsum_q + PW'(prod);
          k_q     <= 2'd2;
          state_q <= S_B2;
        end
        S_B2: begin
          bsum_q  <= bsum_q + PW'(prod);
          k_q     <= '0;
          state_q <= S_PUB;
        end
        S_PUB: begin
          upd_q   <= !(bsum_q < PW'(cfg_i.min_publish_sq));
          state_q <= (bsum_q < PW'(cfg_i.min_publish_sq)) ? S_LOAD : S_FM1;
        end
        S_FM1: begin
          acc_q   <= AW'(prod);
          state_q <= S_FM2;
        end
        S_FM2: begin
          acc_q   <= acc_q + (AW'(prod) <<< FRAC_BITS);
          state_q <= S_FRND;
        end
        S_FRND: begin
          filt_q[k_q] <= fnew;
          k_q         <= k_q + 1'b1;
          state_q     <= (k_q == 2'd2) ? S_LOAD : S_FM1;
        end
        S_LOAD: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_q        <= ov;
            out_upd_q    <= upd_q;
            have_prev_q  <= 1'b0;
            best_key_q   <= KW'(BestKeyReset);
            for (int i = 0; i < 3; i++) begin
              best_pt_q[i] <= '0;
            end
            k_q     <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign smooth_x_o  = out_q[0];
  assign smooth_y_o  = out_q[1];
  assign smooth_z_o  = out_q[2];
  assign updated_o   = out_upd_q;

`ifndef SYNTHESIS
  a_root_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROOT |-> cnt_q < CNTW'(RB)) else $error("root count overrun");
  a_key_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_LOAD |=> best_key_q <= $past(best_key_q)) else $error("best key rose");
  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && out_free) |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded");
`endif

endmodule

// File: rtl/nearest_steep_point_tracker.sv
// top level of the nearest steep point tracker
// Tracks, per lidar scan, the nearest point on a steep surface and smooths it with a Q8
// exponential filter; one word comes out at the last point of every scan. Points enter
// a four word queue, so the input keeps flowing while the back end works, until the
// queue fills. The back end shares one multiplier and a bit-serial square root; a point
// with any zero coordinate is skipped, and the scan end may wait for the previous result
// to be taken. Configuration writes are taken every cycle.
module nearest_steep_point_tracker import nspt_pkg::*; #(
  parameter int unsigned COORD_BITS = 18,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] x_mm_i,
  input  logic signed [COORD_BITS-1:0] y_mm_i,
  input  logic signed [COORD_BITS-1:0] z_mm_i,
  input  logic                         last_in_scan_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] smooth_x_o,
  output logic signed [COORD_BITS-1:0] smooth_y_o,
  output logic signed [COORD_BITS-1:0] smooth_z_o,
  output logic                         updated_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CfgIdxBits-1:0]        cfg_index_i,
  input  logic [CfgDataBits-1:0]       cfg_data_i
);

  localparam int unsigned ItemBits = 3 * COORD_BITS + 3;

  nspt_cfg_t            cfg_q;
  logic                 q_push, q_full, q_pop, q_valid;
  logic [ItemBits-1:0]  q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      case (nspt_reg_e'(cfg_index_i))
        REG_MIRROR_XY:   cfg_q.mirror_xy      <= cfg_data_i[0];
        REG_X_OFFSET:    cfg_q.x_offset_mm    <= cfg_data_i[9:0];
        REG_PAIR_GAP:    cfg_q.pair_gap_mm    <= cfg_data_i[10:0];
        REG_SLOPE_RATIO: cfg_q.slope_ratio_q8 <= cfg_data_i[15:0];
        REG_NEAR_REJECT: cfg_q.near_reject_sq <= cfg_data_i[29:0];
        REG_MIN_PUBLISH: cfg_q.min_publish_sq <= cfg_data_i[29:0];
        REG_SMOOTHING:   cfg_q.smoothing_q8   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  nspt_front #(.COORD_BITS(COORD_BITS), .ITEM_BITS(ItemBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .x_mm_i, .y_mm_i, .z_mm_i,
    .last_in_scan_i, .cfg_i(cfg_q), .q_full_i(q_full), .q_push_o(q_push),
    .q_item_o(q_wdata)
  );

  nspt_fifo #(.WIDTH(ItemBits), .DEPTH(4)) u_fifo (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_wdata), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .data_o(q_rdata)
  );

  nspt_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .ITEM_BITS(ItemBits))
  u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(q_valid), .q_item_i(q_rdata),
    .q_pop_o(q_pop), .out_valid_o, .out_stall_i, .smooth_x_o, .smooth_y_o,
    .smooth_z_o, .updated_o
  );

endmodule
